[rtl/kfi_pkg.sv]
// ----------------------------------------------------------------------------
// kfi_pkg
// Shared types, codes and constants of the keyframe interpolator.
// ----------------------------------------------------------------------------
package kfi_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 1024;
  localparam logic [31:0] FPM_RESET      = 32'd402653;   // about 24 fps in Q8.24

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = 1;

  // v/273 for 12-bit v as (v * 3841) >> 20, exact over the whole range
  localparam logic [11:0] B64_RECIP = 12'd3841;
  localparam int unsigned B64_SHIFT = 20;

  localparam logic [5:0] B64_LOWER_OFS = 6'd26;
  localparam logic [5:0] B64_DIGIT_OFS = 6'd52;
  localparam logic [5:0] B64_PLUS_VAL  = 6'd62;
  localparam logic [5:0] B64_SLASH_VAL = 6'd63;

  typedef enum logic [1:0] {
    ACT_QUERY = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_RAW   = 2'd2,
    ACT_B64   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } st_t;

  // decoded work for the back end; HOLD reports the count only
  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_HOLD   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] data;   // position for a query, frame code for an append
  } cmd_t;

  function automatic logic [5:0] b64_value(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin          // A-Z
      v = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin // a-z
      v = 6'(c - 8'h61) + B64_LOWER_OFS;
    end else if (c inside {[8'h30:8'h39]}) begin // 0-9
      v = 6'(c - 8'h30) + B64_DIGIT_OFS;
    end else if (c == 8'h2B) begin               // '+'
      v = B64_PLUS_VAL;
    end else if (c == 8'h2F) begin               // '/'
      v = B64_SLASH_VAL;
    end
    return v;
  endfunction

endpackage

[rtl/kfi_front.sv]
// ----------------------------------------------------------------------------
// kfi_front
// Accepts input beats, pairs base64 characters and issues back-end commands.
// ----------------------------------------------------------------------------
module kfi_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  input  logic [31:0]   in_position_ms,
  input  logic [15:0]   in_raw_frame,
  input  logic [7:0]    in_b64_char,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output kfi_pkg::cmd_t cmd
);
  import kfi_pkg::*;

  logic [5:0]  pending_high_r, pending_high_nxt;
  logic        have_high_r, have_high_nxt;
  logic [5:0]  b64_t;
  logic [11:0] v;
  logic [23:0] v_mul;
  logic [15:0] b64_code;
  logic        accept;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  assign b64_t    = b64_value(in_b64_char);
  assign v        = {pending_high_r, b64_t};
  assign v_mul    = v * B64_RECIP;
  // 16v + v/273, the 12-bit value scaled to full 16-bit range
  assign b64_code = {v, 4'b0000} + 16'(v_mul[23:B64_SHIFT]);

  always_comb begin
    pending_high_nxt = pending_high_r;
    have_high_nxt    = have_high_r;
    cmd.kind         = CMD_HOLD;
    cmd.data         = 32'd0;
    case (in_action)
      ACT_QUERY: begin
        cmd.kind = CMD_QUERY;
        cmd.data = in_position_ms;
      end
      ACT_CLEAR: begin
        cmd.kind         = CMD_CLEAR;
        pending_high_nxt = 6'd0;
        have_high_nxt    = 1'b0;
      end
      ACT_RAW: begin
        cmd.kind = CMD_APPEND;
        cmd.data = {16'd0, in_raw_frame};
      end
      ACT_B64: begin
        if (have_high_r) begin
          cmd.kind         = CMD_APPEND;
          cmd.data         = {16'd0, b64_code};
          pending_high_nxt = 6'd0;
          have_high_nxt    = 1'b0;
        end else begin
          pending_high_nxt = b64_t;
          have_high_nxt    = 1'b1;
        end
      end
      default: begin
        cmd.kind = CMD_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_high_r <= 6'd0;
      have_high_r    <= 1'b0;
    end else if (accept) begin
      pending_high_r <= pending_high_nxt;
      have_high_r    <= have_high_nxt;
    end
  end

endmodule

[rtl/kfi_cmdq.sv]
// ----------------------------------------------------------------------------
// kfi_cmdq
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module kfi_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  kfi_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output kfi_pkg::cmd_t pop_cmd
);
  import kfi_pkg::*;

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   fill_r;
  logic               do_push, do_pop;

  function automatic logic [CMDQ_AW-1:0] next_ptr(input logic [CMDQ_AW-1:0] p);
    logic [CMDQ_AW-1:0] n;
    if (p == CMDQ_AW'(CMDQ_DEPTH - 1)) n = '0;
    else n = p + CMDQ_AW'(1);
    return n;
  endfunction

  assign push_ready = (fill_r != (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= next_ptr(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= next_ptr(rd_ptr_r);
      if (do_push && !do_pop)      fill_r <= fill_r + (CMDQ_AW + 1)'(1);
      else if (do_pop && !do_push) fill_r <= fill_r - (CMDQ_AW + 1)'(1);
    end
  end

endmodule

[rtl/kfi_back.sv]
// ----------------------------------------------------------------------------
// kfi_back
// Executes commands: owns the keyframe store, the frame count, the query
// datapath and the output register.
// ----------------------------------------------------------------------------
module kfi_back #(
  parameter int unsigned MAX_FRAMES = kfi_pkg::MAX_FRAMES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     frames_per_ms,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  kfi_pkg::cmd_t   cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_level,
  output kfi_pkg::st_t    out_status,
  output logic [10:0]     out_count
);
  import kfi_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_FRAMES);
  localparam int unsigned CW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IDX_W = 40;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ADDR = 5'b00100,
    S_MUL2 = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] mem [MAX_FRAMES];

  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    out_level_r, out_level_nxt;
  st_t            out_status_r, out_status_nxt;
  logic [10:0]    out_count_r, out_count_nxt;
  logic [CW+10:0] count_ext;

  logic [31:0]        pos_r;
  logic [63:0]        prod_r;
  logic [15:0]        frac_r;
  logic               at_end_r;
  logic [15:0]        rd_a_r, rd_b_r;
  logic [15:0]        start_r;
  logic signed [33:0] dprod_r;
  logic               at_end_hold_r;

  logic              out_free, pop, full;
  logic              mem_we, mem_re;
  logic [AW-1:0]     wr_addr, ra, rb;
  logic [CW-1:0]     last;
  logic [IDX_W-1:0]  idx;
  logic              at_end;
  logic signed [16:0] diff, frac_s;
  logic [17:0]       sum;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign pop       = cmd_valid && cmd_ready;
  assign full      = (count_r == CW'(MAX_FRAMES));

  assign wr_addr = count_r[AW-1:0];
  assign mem_we  = pop && (cmd.kind == CMD_APPEND) && !full;

  assign last   = count_r - CW'(1);
  assign idx    = prod_r[63:24];
  assign at_end = (idx >= {{(IDX_W - CW){1'b0}}, last});
  assign ra     = at_end ? last[AW-1:0] : idx[AW-1:0];
  assign rb     = idx[AW-1:0] + AW'(1);
  assign mem_re = (state_r == S_ADDR);

  assign diff   = signed'({1'b0, rd_b_r}) - signed'({1'b0, rd_a_r});
  assign frac_s = signed'({1'b0, frac_r});
  // arithmetic shift of the product floors towards minus infinity
  assign sum    = {2'b00, start_r} + 18'(dprod_r[33:16]);

  assign count_ext = {11'd0, count_nxt};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_level_nxt  = out_level_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          out_level_nxt  = 16'd0;
          out_status_nxt = ST_OK;
          case (cmd.kind)
            CMD_QUERY: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_MUL;
              end
            end
            CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_APPEND: begin
              if (full) out_status_nxt = ST_FULL;
              else count_nxt = count_r + CW'(1);
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_count_nxt = count_ext[10:0];
        end
      end
      S_MUL:  state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          out_level_nxt  = at_end_hold_r ? start_r : sum[15:0];
          out_status_nxt = ST_OK;
          out_count_nxt  = count_ext[10:0];
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // keyframe store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= cmd.data[15:0];
    if (mem_re) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) pos_r <= cmd.data;
    if (state_r == S_MUL) prod_r <= 64'(pos_r) * 64'(frames_per_ms);
    if (state_r == S_ADDR) begin
      frac_r   <= prod_r[23:8];
      at_end_r <= at_end;
    end
    if (state_r == S_MUL2) begin
      dprod_r       <= diff * frac_s;
      start_r       <= rd_a_r;
      at_end_hold_r <= at_end_r;
    end
    out_level_r  <= out_level_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

[rtl/keyframe_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// keyframe_interpolator_unit
// Keyframe store with raw and base64 loading and linear level interpolation.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                               tuser
// in_       in   position_ms[31:0] raw_frame[47:32] b64_char[55:48] action
// out_      out  level[15:0] frame_count[26:16] zero[31:27]      status
// cfg_      in   frames_per_ms, written when cfg_we is high        -
//
// The front end takes one beat per cycle while the two-entry command queue
// has room. The back end finishes clear, append and base64 beats from idle;
// a query on a non-empty store steps through the 64-bit position multiply,
// dual-port store read, 17x17 difference multiply and the final add.
// Reset is synchronous; the store itself is not cleared (no clearing pass).
// A stalled result sits in the output register while the queue keeps filling.
// ----------------------------------------------------------------------------
module keyframe_interpolator_unit #(
  parameter int unsigned MAX_FRAMES = kfi_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // position_ms, raw_frame, b64_char
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // level, frame_count, zero pad
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import kfi_pkg::*;

  localparam logic [10:0] FULL_COUNT = 11'(MAX_FRAMES % 2048);

  logic [31:0] fpm_r;
  logic        q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  cmd_t        q_push_cmd, q_pop_cmd;
  logic [15:0] level;
  st_t         status;
  logic [10:0] frame_count;

  always_ff @(posedge clk) begin
    if (!rst_n) fpm_r <= FPM_RESET;
    else if (cfg_we) fpm_r <= cfg_wdata;
  end

  kfi_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_action     (in_tuser),
    .in_position_ms(in_tdata[31:0]),
    .in_raw_frame  (in_tdata[47:32]),
    .in_b64_char   (in_tdata[55:48]),
    .cmd_valid     (q_push_valid),
    .cmd_ready     (q_push_ready),
    .cmd           (q_push_cmd)
  );

  kfi_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_cmd  (q_push_cmd),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd)
  );

  kfi_back #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .frames_per_ms(fpm_r),
    .cmd_valid    (q_pop_valid),
    .cmd_ready    (q_pop_ready),
    .cmd          (q_pop_cmd),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_level    (level),
    .out_status   (status),
    .out_count    (frame_count)
  );

  assign out_tdata = {5'd0, frame_count, level};
  assign out_tuser = status;

  // empty-store query reports nothing held and no level
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> out_tdata[26:0] == 27'd0)
    else $error("empty status with nonzero level or count");

  // a dropped frame means the store was full
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |->
      (out_tdata[26:16] == FULL_COUNT) && (out_tdata[15:0] == 16'd0))
    else $error("full status without a full store");

  // a result beat held back must not change under the receiver
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Bench for keyframe_interpolator_unit. A short directed table loads keyframes
// by raw codes and base64 pairs, then queries, clears and re-loads. After that
// come random phases, the fill ones running the store past full, each with a
// frame rate and idling pattern. Known rows are checked against the listed
// result, others against a predictor of store, base64 half and interpolation.
// ----------------------------------------------------------------------------
module tb_top;
  import kfi_pkg::*;

  localparam int unsigned DEPTH       = MAX_FRAMES_DEF;
  localparam int          N_DIR       = 27;
  localparam int          N_PHASES    = 8;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 4000;
  localparam int          TAIL_CYCLES = 12;

  typedef struct packed {
    logic [15:0] level;
    st_t         status;
    logic [10:0] count;
  } kf_result_t;

  typedef struct packed {
    act_t        act;
    logic [31:0] pos;
    logic [15:0] raw;
    logic [7:0]  ch;
    bit          known;
    kf_result_t  want;
  } dir_row_t;

  typedef struct {
    int          items;
    int          send_pct;
    int          recv_pct;
    logic [31:0] rate;
    bit          fill;
    int          hold_at;
    int          drain_at;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // position_ms, raw_frame, b64_char
  logic [1:0]  in_tuser = '0;   // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // level, frame_count, zero pad
  logic [1:0]  out_tuser;       // status
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  keyframe_interpolator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // predicted block state
  logic [15:0] key_levels [DEPTH];
  logic [10:0] key_count;
  logic [5:0]  half_hi;
  bit          half_valid;
  logic [31:0] rate_q824;

  kf_result_t  pending_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fails = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_interp = 0;
  int n_drops = 0;
  int quiet_cycles = 0;

  dir_row_t dir_tab [N_DIR];
  phase_t   phase_tab [N_PHASES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- predictor --------------------------------------------------------

  task automatic push_level(input logic [15:0] code, output st_t st);
    if (key_count >= DEPTH) begin
      st = ST_FULL;
      n_drops++;
    end else begin
      key_levels[key_count] = code;
      key_count = key_count + 11'd1;
      st = ST_OK;
    end
  endtask

  task automatic model_action(input act_t a, input logic [31:0] pos,
                              input logic [15:0] raw, input logic [7:0] ch,
                              output kf_result_t r);
    logic [63:0]    prod;
    logic [39:0]    idx;
    logic [15:0]    frac;
    logic [10:0]    last;
    logic [5:0]     sx;
    logic [11:0]    v;
    int unsigned    j;
    longint signed  diff;
    longint signed  step;
    r = '0;
    r.status = ST_OK;
    case (a)
      ACT_QUERY: begin
        if (key_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          prod = {32'd0, pos} * {32'd0, rate_q824};
          idx  = prod[63:24];
          frac = prod[23:8];
          last = key_count - 11'd1;
          if (idx >= {29'd0, last}) begin
            r.level = key_levels[last];
          end else begin
            j    = idx[10:0];
            diff = longint'(key_levels[j+1]) - longint'(key_levels[j]);
            // arithmetic shift of a signed product floors toward minus infinity
            step = (diff * longint'(frac)) >>> 16;
            r.level = 16'(longint'(key_levels[j]) + step);
            n_interp++;
          end
        end
      end
      ACT_CLEAR: begin
        key_count  = '0;
        half_hi    = '0;
        half_valid = 1'b0;
      end
      ACT_RAW: begin
        push_level(raw, r.status);
      end
      default: begin
        if (ch >= 8'h41 && ch <= 8'h5A) sx = 6'(ch - 8'h41);
        else if (ch >= 8'h61 && ch <= 8'h7A) sx = 6'(ch - 8'h61) + B64_LOWER_OFS;
        else if (ch >= 8'h30 && ch <= 8'h39) sx = 6'(ch - 8'h30) + B64_DIGIT_OFS;
        else if (ch == 8'h2B) sx = B64_PLUS_VAL;
        else if (ch == 8'h2F) sx = B64_SLASH_VAL;
        else sx = '0;
        if (half_valid) begin
          v = {half_hi, sx};
          push_level(16'({v, 4'd0}) + 16'(v / 12'd273), r.status);
          half_hi    = '0;
          half_valid = 1'b0;
        end else begin
          half_hi    = sx;
          half_valid = 1'b1;
        end
      end
    endcase
    r.count = key_count;
  endtask

  // ---- input side -------------------------------------------------------

  task automatic send_beat(input act_t a, input logic [31:0] pos,
                           input logic [15:0] raw, input logic [7:0] ch,
                           input bit known, input kf_result_t typed);
    kf_result_t r;
    bit         taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ch, raw, pos};
    in_tuser  <= a;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_tready;
    end
    model_action(a, pos, raw, ch, r);
    if (known) r = typed;
    pending_results = {pending_results, r};
    n_sent++;
    @(negedge clk);
  endtask

  task automatic random_beat(input bit fill);
    int unsigned roll;
    act_t        a;
    logic [31:0] pos;
    logic [15:0] raw;
    logic [7:0]  ch;
    logic [5:0]  sx;
    logic [63:0] target;
    roll = $urandom_range(99);
    if (fill) begin
      a = (roll < 70) ? ACT_RAW : (roll < 90) ? ACT_B64 : ACT_QUERY;
    end else begin
      a = (roll < 4) ? ACT_CLEAR : (roll < 34) ? ACT_RAW :
          (roll < 64) ? ACT_B64 : ACT_QUERY;
    end
    pos = $urandom;
    raw = 16'($urandom);
    ch  = 8'($urandom);
    if (a == ACT_B64 && $urandom_range(99) < 85) begin
      sx = 6'($urandom);
      if (sx < 26) ch = 8'h41 + 8'(sx);
      else if (sx < 52) ch = 8'h61 + 8'(sx) - 8'd26;
      else if (sx < 62) ch = 8'h30 + 8'(sx) - 8'd52;
      else if (sx == 62) ch = 8'h2B;
      else ch = 8'h2F;
    end
    // aim most queries at an index up to the frame count, with a random fraction
    if (a == ACT_QUERY && rate_q824 != 0 && $urandom_range(99) < 80) begin
      target = (64'($urandom_range(0, key_count)) << 24) | 64'($urandom & 32'hFF_FFFF);
      target = target / {32'd0, rate_q824};
      pos = (target > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : target[31:0];
    end
    send_beat(a, pos, raw, ch, 1'b0, '0);
  endtask

  task automatic pause_and_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_rate(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rate_q824 = value;
  endtask

  // ---- output side ------------------------------------------------------

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen++;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_check
    kf_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got level %0h status %0d count %0d",
                 $time, out_tdata[15:0], out_tuser, out_tdata[26:16]);
        fails++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("level", want.level, out_tdata[15:0]);
        check_field("status", 16'(want.status), 16'(out_tuser));
        check_field("frame_count", 16'(want.count), 16'(out_tdata[26:16]));
        check_field("pad", 16'd0, 16'(out_tdata[31:27]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---- sequence ---------------------------------------------------------

  initial begin
    key_count  = '0;
    half_hi    = '0;
    half_valid = 1'b0;
    rate_q824  = FPM_RESET;

    // stored frames after row 13: 1008 65535 0 65535 816 63502 4660 54236
    dir_tab = '{
      '{ACT_QUERY, 32'd0,          16'h0000, 8'h00, 1'b1, '{16'd0, ST_EMPTY, 11'd0}},
      '{ACT_B64,   32'd0,          16'h0000, "A",   1'b1, '{16'd0, ST_OK,    11'd0}},
      '{ACT_B64,   32'hFFFF_FFFF,  16'hFFFF, "/",   1'b1, '{16'd0, ST_OK,    11'd1}},
      '{ACT_RAW,   32'd0,          16'hFFFF, 8'h00, 1'b1, '{16'd0, ST_OK,    11'd2}},
      '{ACT_RAW,   32'hFFFF_FFFF,  16'h0000, 8'hFF, 1'b1, '{16'd0, ST_OK,    11'd3}},
      '{ACT_B64,   32'd0,          16'h0000, "/",   1'b1, '{16'd0, ST_OK,    11'd3}},
      '{ACT_B64,   32'd0,          16'h0000, "/",   1'b1, '{16'd0, ST_OK,    11'd4}},
      '{ACT_B64,   32'd0,          16'h0000, 8'h2A, 1'b1, '{16'd0, ST_OK,    11'd4}},
      '{ACT_B64,   32'd0,          16'h0000, "z",   1'b1, '{16'd0, ST_OK,    11'd5}},
      '{ACT_B64,   32'd0,          16'h0000, "+",   1'b1, '{16'd0, ST_OK,    11'd5}},
      '{ACT_B64,   32'd0,          16'h0000, 8'hFF, 1'b1, '{16'd0, ST_OK,    11'd6}},
      '{ACT_B64,   32'd0,          16'h0000, "0",   1'b1, '{16'd0, ST_OK,    11'd6}},
      '{ACT_RAW,   32'd0,          16'h1234, "a",   1'b1, '{16'd0, ST_OK,    11'd7}},
      '{ACT_B64,   32'd0,          16'h0000, "9",   1'b1, '{16'd0, ST_OK,    11'd8}},
      '{ACT_QUERY, 32'd0,          16'h0000, 8'h00, 1'b1, '{16'd1008, ST_OK,  11'd8}},
      '{ACT_QUERY, 32'hFFFF_FFFF,  16'h0000, 8'h00, 1'b1, '{16'd54236, ST_OK, 11'd8}},
      '{ACT_QUERY, 32'd62,         16'h0000, 8'h00, 1'b0, '0},
      '{ACT_QUERY, 32'd100,        16'h0000, 8'h00, 1'b0, '0},
      '{ACT_QUERY, 32'd250,        16'h0000, 8'h00, 1'b0, '0},
      '{ACT_QUERY, 32'd292,        16'h0000, 8'h00, 1'b0, '0},
      '{ACT_CLEAR, 32'd0,          16'hFFFF, 8'hFF, 1'b1, '{16'd0, ST_OK,    11'd0}},
      '{ACT_QUERY, 32'd5,          16'h0000, 8'h00, 1'b1, '{16'd0, ST_EMPTY, 11'd0}},
      '{ACT_B64,   32'd0,          16'h0000, "Q",   1'b1, '{16'd0, ST_OK,    11'd0}},
      '{ACT_CLEAR, 32'd0,          16'h0000, 8'h00, 1'b1, '{16'd0, ST_OK,    11'd0}},
      '{ACT_B64,   32'd0,          16'h0000, "A",   1'b1, '{16'd0, ST_OK,    11'd0}},
      '{ACT_B64,   32'd0,          16'h0000, "B",   1'b1, '{16'd0, ST_OK,    11'd1}},
      '{ACT_QUERY, 32'h1234_5678,  16'h0000, 8'h00, 1'b1, '{16'd16, ST_OK,   11'd1}}
    };

    // fill phases never clear, so the store runs full during the fifth
    phase_tab[0] = '{300, 0,  0,  FPM_RESET,                      1'b1, -1, -1};
    phase_tab[1] = '{300, 69, 0,  32'hFFFF_FFFF,                  1'b1, -1, -1};
    phase_tab[2] = '{300, 0,  69, 32'd0,                          1'b1, -1, -1};
    phase_tab[3] = '{300, 23, 23, $urandom,                       1'b1, -1, -1};
    phase_tab[4] = '{200, 0,  0,  FPM_RESET,                      1'b1, 20, -1};
    phase_tab[5] = '{150, 69, 0,  32'($urandom_range(1, 2000000)), 1'b0, -1, 75};
    phase_tab[6] = '{150, 0,  69, 32'd1,                          1'b0, -1, -1};
    phase_tab[7] = '{150, 23, 23, $urandom,                       1'b0, -1, -1};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[k]) begin
      send_beat(dir_tab[k].act, dir_tab[k].pos, dir_tab[k].raw, dir_tab[k].ch,
                dir_tab[k].known, dir_tab[k].want);
    end

    foreach (phase_tab[p]) begin
      pause_and_drain();
      write_rate(phase_tab[p].rate);
      send_idle_pct  = phase_tab[p].send_pct;
      recv_stall_pct = phase_tab[p].recv_pct;
      for (int i = 0; i < phase_tab[p].items; i++) begin
        if (i == phase_tab[p].hold_at) hold_reqs++;
        if (i == phase_tab[p].drain_at) pause_and_drain();
        random_beat(phase_tab[p].fill);
      end
    end

    pause_and_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fails++;
    end

    $display("run covered %0d beats in over %0d rate settings, %0d results checked",
             n_sent, N_PHASES, n_checked);
    $display("%0d queries interpolated between frames, %0d frames dropped on a full store",
             n_interp, n_drops);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
